### src/gyi_pkg.sv
// Shared types and constants of the gyro yaw integrator.
package gyi_pkg;

   // Fixed field widths
   localparam int RAW_W      = 16;
   localparam int TICK_W     = 32;
   localparam int COUNT_W    = 16;
   localparam int CALSUM_W   = 32;
   localparam int BIAS_W     = 40;
   localparam int MAG_W      = 40;
   localparam int YAW_OUT_W  = 25;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int FUNC_W     = 2;

   // Bias fraction bits and the rate scale 131 LSB per deg/s times 1000 ms per s
   localparam int BIAS_FRAC  = 23;
   localparam int RATE_DEN   = 131000;
   localparam int RATE_HALF  = 65500;
   localparam int DEN_W      = 17;

   // Calibration run length after reset
   localparam logic [COUNT_W-1:0] CFG_COUNT_RESET = 16'd500;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_CAL     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_YAW     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   // Status of a bit-serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAL_ADD,
      ST_CAL_CHK,
      ST_CAL_DIV,
      ST_CAL_SET,
      ST_YAW_DT,
      ST_YAW_ABS,
      ST_YAW_MUL,
      ST_YAW_DIV,
      ST_YAW_ADD,
      ST_YAW_WRAP,
      ST_OUT
   } state_type;

endpackage

### src/gyi_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module gyi_sdiv #(
   parameter int NUM_W = 58,
   parameter int DIV_DEN_W = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_W-1:0]         num,
   input  logic [DIV_DEN_W-1:0]     den,
   output gyi_pkg::unit_stat_type   stat,
   output logic [NUM_W-1:0]         quot
);
   import gyi_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]     num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   trial_sub;
   logic                 fits;

   // Trial subtract of the divisor from the partial remainder
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = (trial >= {1'b0, den_ff});

   // Load on start, then shift one numerator bit out and one quotient bit in
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == '0);
   assign quot      = num_ff;

endmodule

### src/gyi_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module gyi_smul #(
   parameter int A_W = 40,
   parameter int B_W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [A_W-1:0]           a,
   input  logic [B_W-1:0]           b,
   output gyi_pkg::unit_stat_type   stat,
   output logic [A_W+B_W-1:0]       prod
);
   import gyi_pkg::*;

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic [P_W-1:0]   acc_ff, acc_in;
   logic [P_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   // Load on start, then add the shifted multiplicand for each set bit, LSB first
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = '0;
         a_in    = P_W'(a);
         b_in    = b;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == '0);
   assign prod      = acc_ff;

endmodule

### src/gyro_yaw_integrator.sv
// Top level of the gyro yaw integrator: sequencer, state and output register.
//
// Each request carries a function code, a signed raw Z-rate sample and a
// millisecond tick, and yields one response with the yaw in degrees (Q16)
// and the bias-valid flag. Requests are taken one at a time; the response
// sits in an output register, so the next request is taken while it waits.
// A yaw sample runs a bit-serial multiply of the rate by the elapsed time,
// one bit per cycle, and then the shared bit-serial divider, which produces
// one quotient bit per cycle; the sample that closes a calibration run also
// uses the divider. The divider is DIV_W = max(55, FRAC_BITS + DT_W + 18)
// bits wide, where DT_W is the bit count of MAX_DT_MS.
module gyro_yaw_integrator #(
   parameter int MAX_DT_MS = 255,
   parameter int FRAC_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gyi_pkg::REQ_DATA_W-1:0]    req_tdata,  // gyro_z_raw[15:0], tick_ms[47:16]
   input  logic [gyi_pkg::FUNC_W-1:0]        req_tuser,  // func[1:0]
   // Response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gyi_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // yaw_q16[24:0], zero[31:25]
   output logic                              rsp_tuser,  // bias_valid[0]
   // Configuration
   input  logic                              csr_wr_en,
   input  logic [gyi_pkg::COUNT_W-1:0]       csr_wr_data
);
   import gyi_pkg::*;

   localparam int DT_W    = $clog2(MAX_DT_MS + 1);
   localparam int ACC_W   = FRAC_BITS + 10;
   localparam int DIFF_W  = BIAS_W + 1;
   localparam int PROD_W  = MAG_W + DT_W;
   localparam int SH_L    = (FRAC_BITS >= BIAS_FRAC) ? (FRAC_BITS - BIAS_FRAC) : 0;
   localparam int SH_R    = (FRAC_BITS >= BIAS_FRAC) ? 0 : (BIAS_FRAC - FRAC_BITS);
   localparam int YNUM_W  = PROD_W + FRAC_BITS - BIAS_FRAC + 1;
   localparam int CNUM_W  = CALSUM_W + BIAS_FRAC;
   localparam int DIV_W   = (YNUM_W > CNUM_W) ? YNUM_W : CNUM_W;
   localparam int OUT_SH  = FRAC_BITS - 16;

   localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] FULL_TURN = ACC_W'(360) << FRAC_BITS;

   // Sequencer
   state_type state_ff, state_in;

   // Architectural state
   logic signed [ACC_W-1:0]    yaw_ff, yaw_in;
   logic [BIAS_W-1:0]          bias_ff, bias_in;
   logic [CALSUM_W-1:0]        sum_ff, sum_in;
   logic [COUNT_W-1:0]         seen_ff, seen_in;
   logic [TICK_W-1:0]          last_tick_ff, last_tick_in;
   logic                       bias_done_ff, bias_done_in;
   logic [COUNT_W-1:0]         cfg_count_ff, cfg_count_in;

   // Request and working registers
   logic [RAW_W-1:0]           raw_ff, raw_in;
   logic [TICK_W-1:0]          tick_ff, tick_in;
   logic [DT_W-1:0]            dt_ff, dt_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       yaw_neg_ff, yaw_neg_in;
   logic [CALSUM_W-1:0]        cal_mag_ff, cal_mag_in;
   logic                       cal_neg_ff, cal_neg_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [YAW_OUT_W-1:0]       rsp_yaw_ff, rsp_yaw_in;
   logic                       rsp_bias_ff, rsp_bias_in;

   // Sequencer outputs
   logic                       mul_start;
   logic                       div_start;
   logic                       out_load;

   // Arithmetic units
   unit_stat_type              mul_stat;
   unit_stat_type              div_stat;
   logic [PROD_W-1:0]          mul_prod;
   logic [DIV_W-1:0]           div_num;
   logic [DEN_W-1:0]           div_den;
   logic [DIV_W-1:0]           div_quot;

   // Datapath helpers
   logic [COUNT_W-1:0]         need;
   logic [COUNT_W-1:0]         seen_inc;
   logic [TICK_W-1:0]          tick_gap;
   logic [DIFF_W-1:0]          raw_scaled;
   logic [DIV_W-1:0]           yaw_num;
   logic [DIV_W-1:0]           cal_num;
   logic signed [ACC_W-1:0]    yaw_step;
   logic [BIAS_W-1:0]          bias_mag;
   logic [YAW_OUT_W-1:0]       yaw_round;

   assign need       = (cfg_count_ff == '0) ? COUNT_W'(1) : cfg_count_ff;
   assign seen_inc   = seen_ff + 1'b1;
   assign tick_gap   = tick_ff - last_tick_ff;
   assign raw_scaled = {{(DIFF_W - RAW_W - BIAS_FRAC){raw_ff[RAW_W-1]}}, raw_ff,
                        {BIAS_FRAC{1'b0}}};
   assign yaw_num    = ((DIV_W'(mul_prod) << SH_L) >> SH_R) + DIV_W'(RATE_HALF);
   assign cal_num    = DIV_W'({cal_mag_ff, BIAS_FRAC'(seen_ff[COUNT_W-1:1])});
   assign yaw_step   = div_quot[ACC_W-1:0];
   assign bias_mag   = div_quot[BIAS_W-1:0];

   // Round the accumulator to Q16, ties toward plus infinity
   generate
      if (OUT_SH == 0) begin : g_round_none
         assign yaw_round = yaw_ff[YAW_OUT_W-1:0];
      end else begin : g_round_half
         logic signed [ACC_W-1:0] yaw_half;
         assign yaw_half  = yaw_ff + (ACC_W'(1) << (OUT_SH - 1));
         assign yaw_round = YAW_OUT_W'(yaw_half >>> OUT_SH);
      end
   endgenerate

   // Share the divider between the bias average and the yaw step
   assign div_num = (state_ff == ST_CAL_DIV) ? cal_num : yaw_num;
   assign div_den = (state_ff == ST_CAL_DIV) ? DEN_W'(seen_ff) : DEN_W'(RATE_DEN);

   gyi_smul #(
      .A_W (MAG_W),
      .B_W (DT_W)
   ) u_smul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mag_ff),
      .b     (dt_ff),
      .stat  (mul_stat),
      .prod  (mul_prod)
   );

   gyi_sdiv #(
      .NUM_W     (DIV_W),
      .DIV_DEN_W (DEN_W)
   ) u_sdiv (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  FUNC_CAL: state_in = ST_CAL_ADD;
                  FUNC_YAW: state_in = ST_YAW_DT;
                  default:  state_in = ST_OUT;
               endcase
            end
         end
         ST_CAL_ADD:  state_in = ST_CAL_CHK;
         ST_CAL_CHK:  state_in = (seen_ff >= need) ? ST_CAL_DIV : ST_OUT;
         ST_CAL_DIV:  if (div_stat.done) state_in = ST_CAL_SET;
         ST_CAL_SET:  state_in = ST_OUT;
         ST_YAW_DT:   state_in = ST_YAW_ABS;
         ST_YAW_ABS:  state_in = ST_YAW_MUL;
         ST_YAW_MUL:  if (mul_stat.done) state_in = ST_YAW_DIV;
         ST_YAW_DIV:  if (div_stat.done) state_in = ST_YAW_ADD;
         ST_YAW_ADD:  state_in = ST_YAW_WRAP;
         ST_YAW_WRAP: state_in = ST_OUT;
         ST_OUT:      if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_YAW_MUL: mul_start  = !mul_stat.busy;
         ST_CAL_DIV: div_start  = !div_stat.busy;
         ST_YAW_DIV: div_start  = !div_stat.busy;
         ST_OUT:     out_load   = !rsp_valid_ff || rsp_tready;
         default:    req_tready = 1'b0;
      endcase
   end

   // Datapath next values
   always_comb begin
      yaw_in       = yaw_ff;
      bias_in      = bias_ff;
      sum_in       = sum_ff;
      seen_in      = seen_ff;
      last_tick_in = last_tick_ff;
      bias_done_in = bias_done_ff;
      cfg_count_in = cfg_count_ff;
      raw_in       = raw_ff;
      tick_in      = tick_ff;
      dt_in        = dt_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      yaw_neg_in   = yaw_neg_ff;
      cal_mag_in   = cal_mag_ff;
      cal_neg_in   = cal_neg_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_bias_in  = rsp_bias_ff;
      rsp_valid_in = rsp_valid_ff;

      // Take a configuration write
      if (csr_wr_en) begin
         cfg_count_in = csr_wr_data;
      end

      // Drop the response once it is taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               raw_in  = req_tdata[RAW_W-1:0];
               tick_in = req_tdata[RAW_W+TICK_W-1:RAW_W];
               if (req_tuser == FUNC_RESTART) begin
                  last_tick_in = req_tdata[RAW_W+TICK_W-1:RAW_W];
               end
            end
         end
         ST_CAL_ADD: begin
            sum_in  = sum_ff + {{(CALSUM_W - RAW_W){raw_ff[RAW_W-1]}}, raw_ff};
            seen_in = (seen_inc == '0) ? COUNT_W'(1) : seen_inc;
         end
         ST_CAL_CHK: begin
            cal_neg_in = sum_ff[CALSUM_W-1];
            cal_mag_in = sum_ff[CALSUM_W-1] ? ('0 - sum_ff) : sum_ff;
         end
         ST_CAL_SET: begin
            bias_in      = cal_neg_ff ? ('0 - bias_mag) : bias_mag;
            bias_done_in = 1'b1;
            sum_in       = '0;
            seen_in      = '0;
         end
         ST_YAW_DT: begin
            dt_in        = (tick_gap > TICK_W'(MAX_DT_MS)) ? DT_W'(MAX_DT_MS)
                                                           : tick_gap[DT_W-1:0];
            last_tick_in = tick_ff;
            diff_in      = raw_scaled - {bias_ff[BIAS_W-1], bias_ff};
         end
         ST_YAW_ABS: begin
            yaw_neg_in = diff_ff[DIFF_W-1];
            mag_in     = diff_ff[DIFF_W-1] ? MAG_W'(-diff_ff) : MAG_W'(diff_ff);
         end
         ST_YAW_ADD: begin
            yaw_in = yaw_neg_ff ? (yaw_ff - yaw_step) : (yaw_ff + yaw_step);
         end
         ST_YAW_WRAP: begin
            if (yaw_ff > HALF_TURN) begin
               yaw_in = yaw_ff - FULL_TURN;
            end else if (yaw_ff < -HALF_TURN) begin
               yaw_in = yaw_ff + FULL_TURN;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_yaw_in   = yaw_round;
               rsp_bias_in  = bias_done_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            yaw_in = yaw_ff;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      tick_ff     <= tick_in;
      dt_ff       <= dt_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      yaw_neg_ff  <= yaw_neg_in;
      cal_mag_ff  <= cal_mag_in;
      cal_neg_ff  <= cal_neg_in;
      rsp_yaw_ff  <= rsp_yaw_in;
      rsp_bias_ff <= rsp_bias_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         yaw_ff       <= '0;
         bias_ff      <= '0;
         sum_ff       <= '0;
         seen_ff      <= '0;
         last_tick_ff <= '0;
         bias_done_ff <= 1'b0;
         cfg_count_ff <= CFG_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         yaw_ff       <= yaw_in;
         bias_ff      <= bias_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         last_tick_ff <= last_tick_in;
         bias_done_ff <= bias_done_in;
         cfg_count_ff <= cfg_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_yaw_ff);
   assign rsp_tuser  = rsp_bias_ff;

   // The divider only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_CAL_DIV || state_ff == ST_YAW_DIV))
      else $error("divider finished outside a divide state");

   // The multiplier only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == ST_YAW_MUL))
      else $error("multiplier finished outside the multiply state");

   // Once a calibration run completes the bias stays valid
   assert property (@(posedge clock) disable iff (reset)
      bias_done_ff |=> bias_done_ff)
      else $error("bias valid flag dropped");

   // The yaw is back within half a turn before it is reported
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (yaw_ff <= HALF_TURN && yaw_ff >= -HALF_TURN))
      else $error("yaw outside half a turn at response time");

endmodule

### dv/gyi_checker.sv
`timescale 1ns / 100ps
// Checker of the gyro yaw integrator: watches both channels, predicts each response and compares.
module gyi_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [gyi_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [gyi_pkg::FUNC_W-1:0]       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [gyi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [gyi_pkg::COUNT_W-1:0]      csr_wr_data,
   output int                               fail_count,
   output int                               pending
);
   import gyi_pkg::*;

   // Block built with its default parameters
   localparam int     YAW_FRAC = 32;
   localparam int     DT_CAP   = 255;
   localparam longint YAW_HALF = 64'sd180 <<< YAW_FRAC;
   localparam longint YAW_FULL = 64'sd360 <<< YAW_FRAC;

   typedef struct packed {
      logic [YAW_OUT_W-1:0] yaw;
      logic                 bias_valid;
   } yaw_resp_type;

   // Predicted copy of the block state
   logic [COUNT_W-1:0] cal_len;
   longint             yaw_acc;
   longint             bias_q23;
   int                 cal_sum;
   logic [COUNT_W-1:0] cal_seen;
   logic [TICK_W-1:0]  last_ms;
   logic               bias_ok;

   yaw_resp_type       yaw_resp_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic longint unsigned div_round_nearest(input longint unsigned num,
                                                         input longint unsigned den);
      return (num + den / 2) / den;
   endfunction

   // Yaw increment for one sample over dt ms, rounded on the magnitude
   function automatic longint yaw_rate_delta(input logic signed [RAW_W-1:0] raw,
                                             input logic [TICK_W-1:0] dt);
      longint            diff;
      logic              neg;
      longint unsigned   mag;
      longint unsigned   q;
      longint unsigned   r;
      longint unsigned   res;
      diff = longint'(raw) * 64'sd8388608 - bias_q23;
      neg  = diff < 0;
      mag  = neg ? -diff : diff;
      mag  = mag * longint'(dt);
      q    = mag / RATE_DEN;
      r    = mag % RATE_DEN;
      res  = (q << (YAW_FRAC - BIAS_FRAC))
             + div_round_nearest(r << (YAW_FRAC - BIAS_FRAC), RATE_DEN);
      return neg ? -longint'(res) : longint'(res);
   endfunction

   // Reduce the accumulator to Q16, ties toward plus infinity
   function automatic longint yaw_to_q16(input longint acc);
      longint          v;
      longint unsigned m;
      v = acc + (64'sd1 <<< (YAW_FRAC - 17));
      if (v >= 0) return v >>> (YAW_FRAC - 16);
      m = -v;
      m = (m + ((64'd1 << (YAW_FRAC - 16)) - 1)) >> (YAW_FRAC - 16);
      return -longint'(m);
   endfunction

   // Advance the predicted state by one request
   task automatic apply_request(input logic [FUNC_W-1:0] fn,
                                input logic signed [RAW_W-1:0] raw,
                                input logic [TICK_W-1:0] tick);
      logic [COUNT_W-1:0] need;
      logic               neg;
      longint unsigned    cmag;
      longint unsigned    b;
      logic [TICK_W-1:0]  dt;
      if (fn == FUNC_CAL) begin
         need     = (cal_len == '0) ? 16'd1 : cal_len;
         cal_sum  = cal_sum + int'(raw);
         cal_seen = cal_seen + 16'd1;
         if (cal_seen == '0) cal_seen = 16'd1;
         if (cal_seen >= need) begin
            neg      = cal_sum < 0;
            cmag     = neg ? -longint'(cal_sum) : longint'(cal_sum);
            b        = div_round_nearest(cmag << BIAS_FRAC, longint'(cal_seen));
            bias_q23 = neg ? -longint'(b) : longint'(b);
            bias_ok  = 1'b1;
            cal_sum  = 0;
            cal_seen = '0;
         end
      end else if (fn == FUNC_YAW) begin
         dt = tick - last_ms;
         if (dt > DT_CAP) dt = DT_CAP;
         last_ms = tick;
         yaw_acc = yaw_acc + yaw_rate_delta(raw, dt);
         if (yaw_acc > YAW_HALF) yaw_acc = yaw_acc - YAW_FULL;
         else if (yaw_acc < -YAW_HALF) yaw_acc = yaw_acc + YAW_FULL;
      end else if (fn == FUNC_RESTART) begin
         last_ms = tick;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("checker: %s: got %0h, want %0h", what, got, want);
      fail_count++;
   endtask

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      yaw_resp_type want;
      longint       q16;
      if (reset) begin
         cal_len  = CFG_COUNT_RESET;
         yaw_acc  = 0;
         bias_q23 = 0;
         cal_sum  = 0;
         cal_seen = '0;
         last_ms  = '0;
         bias_ok  = 1'b0;
         yaw_resp_q.delete();
      end else begin
         if (csr_wr_en) cal_len = csr_wr_data;
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[RAW_W-1:0], req_tdata[RAW_W +: TICK_W]);
            q16             = yaw_to_q16(yaw_acc);
            want.yaw        = q16[YAW_OUT_W-1:0];
            want.bias_valid = bias_ok;
            yaw_resp_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (yaw_resp_q.size() == 0) begin
               report_mismatch("response without request", rsp_tdata, 0);
            end else begin
               want = yaw_resp_q.pop_front();
               if (rsp_tdata[YAW_OUT_W-1:0] !== want.yaw)
                  report_mismatch("yaw_q16", rsp_tdata[YAW_OUT_W-1:0], want.yaw);
               if (rsp_tdata[RSP_DATA_W-1:YAW_OUT_W] !== '0)
                  report_mismatch("tdata pad", rsp_tdata[RSP_DATA_W-1:YAW_OUT_W], 0);
               if (rsp_tuser !== want.bias_valid)
                  report_mismatch("bias_valid", rsp_tuser, want.bias_valid);
            end
         end
      end
      pending = yaw_resp_q.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench top of the gyro yaw integrator: clock, reset, request stimulus and verdict.
module tb;
   import gyi_pkg::*;

   localparam int              CYCLE_LIMIT = 1_000_000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [FUNC_W-1:0]     req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;

   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   idle_mode_type         mode = IDLE_NONE;

   // Random phases: run length and idling pattern
   logic [COUNT_W-1:0]    phase_count [5] = '{16'd1, 16'd6, 16'd500, 16'hFFFF, 16'd3};
   idle_mode_type         phase_mode  [5] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                              IDLE_NONE};

   logic [TICK_W-1:0]     tick_now;
   logic [FUNC_W-1:0]     fn;
   logic [RAW_W-1:0]      raw;
   logic [TICK_W-1:0]     tick;
   int                    pick;

   gyro_yaw_integrator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   gyi_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #10 clock = ~clock;

   // Stall the response side as the phase asks
   always @(posedge clock) begin
      case (mode)
         IDLE_RECV: rsp_tready <= $urandom_range(99) >= 73;
         IDLE_BOTH: rsp_tready <= $urandom_range(99) >= 7;
         default:   rsp_tready <= 1'b1;
      endcase
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Offer one request, idling first as the phase asks, and hold it until taken
   task automatic send_req(input logic [FUNC_W-1:0] f, input logic [RAW_W-1:0] r,
                           input logic [TICK_W-1:0] t);
      while ((mode == IDLE_SEND && $urandom_range(99) < 73) ||
             (mode == IDLE_BOTH && $urandom_range(99) < 7)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, r};
      req_tuser  <= f;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off requests until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Uncalibrated yaw: three 51 degree steps and one of 27 land exactly on +180
      send_req(FUNC_RESTART, 16'd0, 32'd100);
      send_req(FUNC_YAW, 16'd26200, 32'd355);
      send_req(FUNC_YAW, 16'd26200, 32'd610);
      send_req(FUNC_YAW, 16'd26200, 32'd865);
      send_req(FUNC_YAW, 16'd26200, 32'd1000);
      // Step past +180 and wrap
      send_req(FUNC_YAW, 16'd26200, 32'd1010);
      // Long gap saturates the elapsed time
      send_req(FUNC_YAW, 16'h8000, 32'hFFFF_FFF0);
      send_req(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      // Tick wraps across zero, then a zero gap
      send_req(FUNC_RESTART, 16'h5A5A, 32'hFFFF_FFF0);
      send_req(FUNC_YAW, 16'h7FFF, 32'h0000_0010);
      send_req(FUNC_YAW, 16'd0, 32'h0000_0010);
      // Count of zero acts as one
      write_count(16'd0);
      send_req(FUNC_CAL, 16'h8000, $urandom);
      send_req(FUNC_YAW, 16'd0, 32'h0000_0100);
      // Lower the count mid-run: the next sample closes the run
      write_count(16'hFFFF);
      send_req(FUNC_CAL, 16'h7FFF, $urandom);
      send_req(FUNC_CAL, 16'hFFFB, $urandom);
      send_req(FUNC_CAL, 16'd100, $urandom);
      write_count(16'd2);
      send_req(FUNC_CAL, 16'd7, $urandom);
      send_req(FUNC_YAW, 16'h7FFF, 32'h0000_0200);
      send_req(FUNC_YAW, 16'h8000, 32'h0000_0300);
      tick_now = 32'h0000_0300;

      // Random phases
      for (int p = 0; p < 5; p++) begin
         write_count(phase_count[p]);
         mode = phase_mode[p];
         for (int n = 0; n < 210; n++) begin
            pick = $urandom_range(99);
            if (pick < 30) fn = FUNC_CAL;
            else if (pick < 85) fn = FUNC_YAW;
            else if (pick < 95) fn = FUNC_RESTART;
            else fn = FUNC_UNUSED;

            pick = $urandom_range(9);
            if (pick == 0) begin
               case ($urandom_range(3))
                  0:       raw = 16'h8000;
                  1:       raw = 16'h7FFF;
                  2:       raw = 16'h0000;
                  default: raw = 16'hFFFF;
               endcase
            end else if (pick < 3) begin
               raw = 16'($urandom_range(400)) - 16'd200;
            end else begin
               raw = 16'($urandom);
            end

            pick = $urandom_range(9);
            if (fn == FUNC_CAL || pick == 8) tick = $urandom;
            else if (pick == 9) tick = tick_now;
            else tick = tick_now + $urandom_range(300);
            if (fn == FUNC_YAW || fn == FUNC_RESTART) tick_now = tick;

            send_req(fn, raw, tick);
            if ($urandom_range(199) == 0) drain();
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
src/gyi_pkg.sv
src/gyi_sdiv.sv
src/gyi_smul.sv
src/gyro_yaw_integrator.sv
dv/gyi_checker.sv
dv/tb.sv
